>>> design/rc4_stream_cipher_defines.svh
// Assertion macros for the RC4 cipher block.
// Used by rc4_stream_cipher.sv; expects clk_i and rst_ni in scope.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RC4_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define RC4_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rc4_pkg.sv
// Shared constants and types for the RC4 cipher block.
// No dependencies; used by rc4_engine and rc4_stream_cipher.
package rc4_pkg;

  localparam int KEY_BYTES_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 5;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

  // Reset key is the ASCII string "Hell", byte 0 in the low bits.
  localparam logic [CFG_DATA_W-1:0] KEY_LOW_RESET  = 64'h0000_0000_6C6C_6548;
  localparam logic [CFG_DATA_W-1:0] KEY_HIGH_RESET = 64'h0;
  localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET  = 5'd4;

  // Engine status toward the top level
  typedef struct packed {
    logic       in_ready;
    logic       res_valid;
    logic [7:0] res_byte;
  } eng_sts_t;

endpackage

>>> design/rc4_engine.sv
// RC4 engine: permutation memory plus the key schedule / keystream sequencer.
// Depends on rc4_pkg.
module rc4_engine #(
  parameter int  KEY_BYTES = rc4_pkg::KEY_BYTES_DEF,
  localparam int KIDX_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   start_of_message_i,
  input  logic                   out_free_i,
  input  logic [KEY_BYTES*8-1:0] key_vec_i,
  input  logic [KIDX_W-1:0]      len_m1_i,
  output rc4_pkg::eng_sts_t      sts_o
);
  import rc4_pkg::*;

  localparam int KEY_SLOTS = 2 ** KIDX_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FILL = 4'd1;  // identity fill
  localparam logic [3:0] ST_KRN  = 4'd2;  // schedule: read S[n], retire last j write
  localparam logic [3:0] ST_KRJ  = 4'd3;  // schedule: new j, read S[j]
  localparam logic [3:0] ST_KWN  = 4'd4;  // schedule: write S[n]
  localparam logic [3:0] ST_KFIN = 4'd5;  // schedule: last j write, read S[1]
  localparam logic [3:0] ST_PB   = 4'd6;  // keystream: S[i] in, read S[j]
  localparam logic [3:0] ST_PC   = 4'd7;  // keystream: write S[i], read S[t]
  localparam logic [3:0] ST_PD   = 4'd8;  // keystream: write S[j], result

  logic [3:0]        st_q, st_d;
  logic              keyed_q, keyed_d;
  logic [7:0]        i_q, i_d;
  logic [7:0]        j_q, j_d;
  logic [7:0]        n_q, n_d;
  logic [KIDX_W-1:0] kidx_q, kidx_d;
  logic              kpend_q, kpend_d;
  logic [7:0]        si_q, si_d;
  logic [7:0]        t_q, t_d;
  logic              hit_q, hit_d;
  logic [7:0]        data_q, data_d;

  // Permutation memory, one write and one registered read per cycle
  logic [7:0] perm_mem [256];
  logic [7:0] rd_raw_q;
  logic [7:0] byp_data_q;
  logic       byp_q;
  logic       we;
  logic [7:0] waddr, wdata, raddr, rdata;

  logic [7:0] key_arr [KEY_SLOTS];
  logic [7:0] key_byte;
  logic [7:0] j_new, t_new, ks;
  logic       ready, acc, res_valid;

  for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_key
    if (k < KEY_BYTES) begin : g_used
      assign key_arr[k] = key_vec_i[k*8 +: 8];
    end else begin : g_pad
      assign key_arr[k] = 8'h00;
    end
  end

  assign key_byte = key_arr[kidx_q];
  // read-during-write returns the new data
  assign rdata    = byp_q ? byp_data_q : rd_raw_q;
  assign j_new    = 8'(j_q + rdata + key_byte);
  assign t_new    = 8'(si_q + rdata);
  // S[t] after the swap: S[j] now holds the old S[i]
  assign ks       = hit_q ? si_q : rdata;

  assign ready = (st_q == ST_IDLE) ||
                 ((st_q == ST_PD) && out_free_i && !start_of_message_i);
  assign acc   = in_valid_i && ready;

  always_comb begin
    st_d      = st_q;
    keyed_d   = keyed_q;
    i_d       = i_q;
    j_d       = j_q;
    n_d       = n_q;
    kidx_d    = kidx_q;
    kpend_d   = kpend_q;
    si_d      = si_q;
    t_d       = t_q;
    hit_d     = hit_q;
    data_d    = data_q;
    we        = 1'b0;
    waddr     = j_q;
    wdata     = si_q;
    raddr     = 8'(i_q + 8'd1);
    res_valid = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (acc) begin
          data_d = data_byte_i;
          if (start_of_message_i || !keyed_q) begin
            st_d    = ST_FILL;
            n_d     = 8'd0;
            i_d     = 8'd0;
            j_d     = 8'd0;
            kidx_d  = '0;
            kpend_d = 1'b0;
          end else begin
            i_d  = 8'(i_q + 8'd1);
            st_d = ST_PB;
          end
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = n_q;
        wdata = n_q;
        n_d   = 8'(n_q + 8'd1);
        if (n_q == 8'hFF) begin
          st_d = ST_KRN;
        end
      end
      ST_KRN: begin
        raddr = n_q;
        we    = kpend_q;
        st_d  = ST_KRJ;
      end
      ST_KRJ: begin
        raddr  = j_new;
        si_d   = rdata;
        j_d    = j_new;
        kidx_d = (kidx_q == len_m1_i) ? '0 : KIDX_W'(kidx_q + 1'b1);
        st_d   = ST_KWN;
      end
      ST_KWN: begin
        we      = 1'b1;
        waddr   = n_q;
        wdata   = rdata;
        kpend_d = 1'b1;
        n_d     = 8'(n_q + 8'd1);
        st_d    = (n_q == 8'hFF) ? ST_KFIN : ST_KRN;
      end
      ST_KFIN: begin
        we      = 1'b1;
        i_d     = 8'(i_q + 8'd1);
        j_d     = 8'd0;
        keyed_d = 1'b1;
        st_d    = ST_PB;
      end
      ST_PB: begin
        raddr = 8'(j_q + rdata);
        j_d   = 8'(j_q + rdata);
        si_d  = rdata;
        st_d  = ST_PC;
      end
      ST_PC: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = rdata;
        raddr = t_new;
        t_d   = t_new;
        hit_d = (t_new == j_q);
        st_d  = ST_PD;
      end
      ST_PD: begin
        we    = 1'b1;
        raddr = t_q;
        if (out_free_i) begin
          res_valid = 1'b1;
          if (acc) begin
            data_d = data_byte_i;
            raddr  = 8'(i_q + 8'd1);
            i_d    = 8'(i_q + 8'd1);
            st_d   = ST_PB;
          end else begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      keyed_q <= 1'b0;
      i_q     <= 8'd0;
      j_q     <= 8'd0;
      n_q     <= 8'd0;
      kidx_q  <= '0;
      kpend_q <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      keyed_q <= keyed_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_q     <= n_d;
      kidx_q  <= kidx_d;
      kpend_q <= kpend_d;
      byp_q   <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    t_q    <= t_d;
    hit_q  <= hit_d;
    data_q <= data_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      perm_mem[waddr] <= wdata;
    end
    rd_raw_q   <= perm_mem[raddr];
    byp_data_q <= wdata;
  end

  assign sts_o.in_ready  = ready;
  assign sts_o.res_valid = res_valid;
  assign sts_o.res_byte  = data_q ^ ks;

endmodule

>>> design/rc4_stream_cipher.sv
// RC4 stream cipher top level: config registers, output register, engine.
// Depends on rc4_pkg, rc4_engine and rc4_stream_cipher_defines.svh.
//
// Each accepted byte is XORed with the next RC4 keystream byte. A byte
// flagged start_of_message_i (or the first byte after reset) first runs
// the key schedule on the current key registers: an identity fill of all
// 256 entries, then 256 mixing steps (read S[n]; new j, read S[j]; write
// S[n]), then one closing step. A new byte is taken while the previous
// result goes out, if the output register is free and the byte carries
// no start flag; the pace is set by the single read port of the
// permutation memory, which must fetch S[i], then S[j], then
// S[S[i]+S[j]] in turn. The permutation needs no clearing pass after
// reset. Key registers: index 0 = key bytes 0..7, index 1 = key bytes
// 8..15, index 2 = key length (0 acts as 1, values above KEY_BYTES
// saturate). Write them only while no byte is in flight.
module rc4_stream_cipher #(
  parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input byte channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            start_of_message_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_byte_o,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rc4_pkg::*;

  `include "rc4_stream_cipher_defines.svh"

  localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  logic [CFG_DATA_W-1:0] key_low_q;
  logic [CFG_DATA_W-1:0] key_high_q;
  logic [KEY_LEN_W-1:0]  key_len_q;
  logic [KEY_LEN_W-1:0]  len_eff;
  logic [KIDX_W-1:0]     len_m1;
  logic [2*CFG_DATA_W-1:0] key_all;
  logic [KEY_BYTES*8-1:0]  key_vec;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_free;
  logic       in_acc;
  eng_sts_t   eng_sts;

  // short names for the checks
  logic       res_v;
  logic [7:0] res_b;
  logic       len_ok;

  // Registers always take a write; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= KEY_LOW_RESET;
      key_high_q <= KEY_HIGH_RESET;
      key_len_q  <= KEY_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LEN:  key_len_q  <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective key length, clamped to 1..KEY_BYTES
  always_comb begin
    if (key_len_q == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (key_len_q > KEY_LEN_W'(KEY_BYTES)) begin
      len_eff = KEY_LEN_W'(KEY_BYTES);
    end else begin
      len_eff = key_len_q;
    end
  end

  assign len_m1  = KIDX_W'(len_eff - KEY_LEN_W'(1));
  assign key_all = {key_high_q, key_low_q};
  assign key_vec = key_all[KEY_BYTES*8-1:0];

  // Output register: refilled in the same cycle it drains.
  assign out_free = !out_valid_q || !out_stall_i;

  rc4_engine #(
    .KEY_BYTES (KEY_BYTES)
  ) u_engine (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .data_byte_i        (data_byte_i),
    .start_of_message_i (start_of_message_i),
    .out_free_i         (out_free),
    .key_vec_i          (key_vec),
    .len_m1_i           (len_m1),
    .sts_o              (eng_sts)
  );

  assign in_stall_o = !eng_sts.in_ready;
  assign in_acc     = in_valid_i && eng_sts.in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_sts.res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_sts.res_valid) begin
      out_byte_q <= eng_sts.res_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // Checks
  assign res_v  = eng_sts.res_valid;
  assign res_b  = eng_sts.res_byte;
  assign len_ok = (len_eff != '0) && (len_eff <= KEY_LEN_W'(KEY_BYTES));

  `RC4_ASSERT_IMP(a_res_into_free_slot, res_v, out_free, "result into a full output")
  `RC4_ASSERT_NXT(a_res_lands, res_v, out_valid_o && (out_byte_o == $past(res_b)), "result lost")
  `RC4_ASSERT_NXT(a_sched_no_early_res, in_acc && start_of_message_i, !res_v, "early result")
  `RC4_ASSERT_IMP(a_len_range, 1'b1, len_ok, "key length out of range")

endmodule

>>> bench/rc4_stream_checker.sv
// Scoreboard for rc4_stream_cipher: watches the byte, result and key channels.
// Depends on rc4_pkg; keeps its own RC4 state and compares every result byte.
`timescale 1ns / 100ps

module rc4_stream_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           start_of_message_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [7:0]                     out_byte_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             pending_o,
  output int                             fail_count_o
);

  import rc4_pkg::*;

  // Shadow key registers and cipher state
  logic [CFG_DATA_W-1:0] key_lo_q;
  logic [CFG_DATA_W-1:0] key_hi_q;
  logic [KEY_LEN_W-1:0]  key_len_q;
  logic [7:0]            sbox [256];
  logic [7:0]            ptr_i;
  logic [7:0]            ptr_j;
  logic                  keyed_q;

  logic [7:0] expected_bytes [$];
  logic [7:0] want;
  int         errors;

  function automatic logic [7:0] key_at(input int n);
    logic [CFG_DATA_W-1:0] word;
    word = (n < 8) ? key_lo_q : key_hi_q;
    return word[(n % 8) * 8 +: 8];
  endfunction

  function automatic void swap_sbox(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] t;
    t       = sbox[a];
    sbox[a] = sbox[b];
    sbox[b] = t;
  endfunction

  function automatic void run_key_schedule();
    int         len;
    logic [7:0] j;
    len = int'(key_len_q);
    if (len == 0) len = 1;
    if (len > KEY_BYTES_DEF) len = KEY_BYTES_DEF;
    for (int n = 0; n < 256; n++) sbox[n[7:0]] = n[7:0];
    j = 8'd0;
    for (int n = 0; n < 256; n++) begin
      j = j + sbox[n[7:0]] + key_at(n % len);
      swap_sbox(n[7:0], j);
    end
    ptr_i   = 8'd0;
    ptr_j   = 8'd0;
    keyed_q = 1'b1;
  endfunction

  function automatic logic [7:0] next_keystream();
    logic [7:0] pos;
    ptr_i = ptr_i + 8'd1;
    ptr_j = ptr_j + sbox[ptr_i];
    swap_sbox(ptr_i, ptr_j);
    pos = sbox[ptr_i] + sbox[ptr_j];
    return sbox[pos];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  = KEY_LOW_RESET;
      key_hi_q  = KEY_HIGH_RESET;
      key_len_q = KEY_LEN_RESET;
      ptr_i     = 8'd0;
      ptr_j     = 8'd0;
      keyed_q   = 1'b0;
      errors    = 0;
      expected_bytes.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_KEY_LOW:  key_lo_q  = cfg_data_i;
          REG_KEY_HIGH: key_hi_q  = cfg_data_i;
          REG_KEY_LEN:  key_len_q = cfg_data_i[KEY_LEN_W-1:0];
          default: ;
        endcase
      end
      // results first: a result never belongs to a byte taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual %02h", $time, out_byte_i);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_i !== want) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want, out_byte_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (start_of_message_i || !keyed_q) run_key_schedule();
        expected_bytes.push_back(data_byte_i ^ next_keystream());
      end
      pending_o    <= expected_bytes.size();
      fail_count_o <= errors;
    end
  end

endmodule

>>> bench/rc4_stream_cipher_tb.sv
// Top-level bench for rc4_stream_cipher: clock, reset, stimulus and verdict.
// Depends on rc4_pkg, rc4_stream_cipher and rc4_stream_checker.
`timescale 1ns / 100ps

module rc4_stream_cipher_tb;

  import rc4_pkg::*;

  localparam int TOTAL_ITEMS = 1950;
  // Index past the register map; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Long receiver hold-off, started once this many bytes have gone in.
  localparam int HOLD_AT     = 140;
  localparam int HOLD_CYCLES = 1500;
  // Window of transfers with no idling on either side.
  localparam int CALM_FROM   = 1000;
  localparam int CALM_TO     = 1300;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i;
  logic                  start_of_message_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [7:0]            out_byte_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int   pending;
  int   fail_count;
  int   sent_count;   // transfers on the byte channel, seen by the receiver
  logic calm_q;       // both sides run without gaps
  logic holding;      // receiver is in its long hold-off

  rc4_stream_cipher u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .start_of_message_i (start_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_byte_o         (out_byte_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  rc4_stream_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .start_of_message_i (start_of_message_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_byte_i         (out_byte_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .pending_o          (pending),
    .fail_count_o       (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Safety net: fails the run if it has not finished in time; the slowest
  // legal run is dominated by key schedules.
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stall about a third of the time, none in the calm
  // window, and one long hold-off so the block backs up into its input.
  initial begin
    bit hold_done;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    holding     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && !hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        holding     <= 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holding     <= 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm_q && ($urandom_range(0, 99) < 34);
      end
    end
  end

  // One byte transfer. Random idle cycles go in front unless calm or the
  // receiver is holding off. valid stays high into the next call when there
  // is no gap, so it is never dropped and raised within one step.
  task automatic send_byte(input logic [7:0] value, input logic som);
    if (!calm_q && !holding) begin
      while ($urandom_range(0, 99) < 34) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i         <= 1'b1;
    data_byte_i        <= value;
    start_of_message_i <= som;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count <= sent_count + 1;
  endtask

  // Register write; the last of a batch drops valid after its transfer.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  // Let every expected result come back, plus a spare idle margin, so that
  // key registers only change while nothing is in flight.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_key(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [63:0] len_word);
    wait_idle();
    cfg_write(REG_KEY_LOW, lo, 1'b0);
    cfg_write(REG_KEY_HIGH, hi, 1'b0);
    cfg_write(REG_KEY_LEN, len_word, 1'b1);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Key word for a random phase: mostly random, sometimes all zeros or ones.
  function automatic logic [63:0] pick_key_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return rand_word();
    endcase
  endfunction

  // Length field with junk above bit 4; covers 0, 1, 16 and saturation.
  function automatic logic [63:0] pick_len_word();
    logic [63:0] w;
    w = rand_word();
    case ($urandom_range(0, 5))
      0:       w[4:0] = 5'd0;
      1:       w[4:0] = 5'd1;
      2:       w[4:0] = 5'd16;
      3:       w[4:0] = 5'($urandom_range(17, 31));
      default: w[4:0] = 5'($urandom_range(2, 15));
    endcase
    return w;
  endfunction

  initial begin
    int          items;
    int          phase_end;
    int          msg_left;
    logic        som;
    logic [63:0] w;

    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    data_byte_i        = 8'h00;
    start_of_message_i = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = REG_KEY_LOW;
    cfg_data_i         = '0;
    calm_q             = 1'b0;
    sent_count         = 0;
    items              = 0;
    msg_left           = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // First byte without a start flag: the block has never keyed, so it
    // must schedule on the reset key "Hell" anyway.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    // restart on the same key: stream starts over
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);

    // All-ones key, length field zero (acts as one) with junk above bit 4,
    // and a write past the register map that must be dropped.
    wait_idle();
    w      = rand_word();
    w[4:0] = 5'd0;
    cfg_write(REG_KEY_LOW, '1, 1'b0);
    cfg_write(REG_KEY_HIGH, '1, 1'b0);
    cfg_write(REG_KEY_LEN, w, 1'b0);
    cfg_write(REG_UNUSED, rand_word(), 1'b1);
    // already keyed: a plain byte keeps the old stream despite the new key
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);

    // full 16-byte key
    program_key(rand_word(), rand_word(), 64'd16);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h00, 1'b0);

    // lengths above the key size saturate to 16
    program_key(rand_word(), rand_word(), 64'd17);
    send_byte(8'hFF, 1'b1);
    program_key(rand_word(), rand_word(), 64'd31);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);

    // all-zero single-byte key
    program_key('0, '0, 64'd1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    items = 16;

    // --- random part ---
    // Phases of a few hundred bytes, each on a fresh key setting. Inside a
    // phase the stream is mostly whole messages: a start byte followed by a
    // run of plain bytes. A few stray start flags land mid-message.
    while (items < TOTAL_ITEMS) begin
      program_key(pick_key_word(), pick_key_word(), pick_len_word());
      if ($urandom_range(0, 3) == 0) begin
        // let valid drop after the batch before it rises again
        @(posedge clk_i);
        cfg_write(REG_UNUSED, rand_word(), 1'b1);
      end
      msg_left  = 0;
      phase_end = items + $urandom_range(150, 400);
      while (items < phase_end && items < TOTAL_ITEMS) begin
        calm_q <= (items >= CALM_FROM && items < CALM_TO);
        if (holding) begin
          // keep offering plain bytes while the receiver is held off
          som = 1'b0;
        end else if (msg_left == 0) begin
          som      = 1'b1;
          msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 30);
        end else begin
          som      = ($urandom_range(0, 99) < 3);
          msg_left = msg_left - 1;
        end
        send_byte(8'($urandom_range(0, 255)), som);
        items++;
      end
    end

    in_valid_i <= 1'b0;
    calm_q     <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/rc4_pkg.sv
design/rc4_engine.sv
design/rc4_stream_cipher.sv
bench/rc4_stream_checker.sv
bench/rc4_stream_cipher_tb.sv
